[src/rhc_pkg.sv]
package rhc_pkg;

    localparam int CH_W              = 8;
    localparam int HUE_W             = 15;
    localparam int HUE_FRAC_BITS_DEF = 6;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
        logic             achromatic;
    } hsv_t;

endpackage

[src/rhc_divider.sv]
// Restoring divider, one quotient bit per register stage, most significant first.
// The quotient must fit in QW bits; it leaves the last stage, and the stages advance only while en is high.
module rhc_divider #(
    parameter int NW = 24,
    parameter int DW = 9,
    parameter int QW = 15
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] rem_reg [QW];
    logic [DW-1:0] dvs_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH   = QW - 1 - k;
        localparam int PREV = (k == 0) ? 0 : k - 1;

        logic [CW-1:0] rem_in;
        logic [DW-1:0] dvs_in;
        logic [QW-1:0] quo_in;
        logic [CW-1:0] dvs_sh;
        logic [CW:0]   diff;
        logic          qbit;
        logic [CW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        assign rem_in = (k == 0) ? CW'(dividend) : rem_reg[PREV];
        assign dvs_in = (k == 0) ? divisor : dvs_reg[PREV];
        assign quo_in = (k == 0) ? '0 : quo_reg[PREV];

        assign dvs_sh   = CW'(dvs_in) << SH;
        assign diff     = {1'b0, rem_in} - {1'b0, dvs_sh};
        assign qbit     = ~diff[CW];
        assign rem_next = qbit ? diff[CW-1:0] : rem_in;
        assign quo_next = quo_in | (QW'(qbit) << SH);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                dvs_reg[k] <= dvs_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quotient = quo_reg[QW-1];

endmodule

[src/rgb_to_hsv_converter_unit.sv]
// Channel  Dir  Payload  Handshake
// pixel    in   rgb_t    pixel_valid / pixel_stall
// hsv      out  hsv_t    hsv_valid / hsv_stall
//
// Accepts one pixel per cycle while hsv is not stalled; the path runs through
// the bit-per-stage hue divider (HUE_FRAC_BITS + 9 stages) plus three
// registers for operand setup, sector/numerator and the output.
// Reset clears only the valid bits. A stall on hsv freezes the whole pipeline
// in place and is passed back as pixel_stall in the same cycle.
module rgb_to_hsv_converter_unit
    import rhc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic pixel_valid,
    output logic pixel_stall,
    input  rgb_t pixel,
    output logic hsv_valid,
    input  logic hsv_stall,
    output hsv_t hsv
);

    localparam int HQW    = 9 + HUE_FRAC_BITS;
    localparam int HNW    = 18 + HUE_FRAC_BITS;
    localparam int SQW    = CH_W;
    localparam int SNW    = 17;
    localparam int DVW    = CH_W + 1;
    localparam int SATPAD = HQW - SQW;
    localparam logic [HQW-1:0] FULL = HQW'(360) << HUE_FRAC_BITS;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    logic adv;
    assign adv         = ~(hsv_valid && hsv_stall);
    assign pixel_stall = ~adv;

    // stage 1: max, min, sector
    logic [CH_W-1:0] mx_c, mn_c;
    logic [1:0]      sec_c;
    logic signed [CH_W:0] n_c;

    always_comb
    begin
        mx_c = (pixel.red > pixel.green) ? pixel.red : pixel.green;
        mx_c = (mx_c > pixel.blue) ? mx_c : pixel.blue;
        mn_c = (pixel.red < pixel.green) ? pixel.red : pixel.green;
        mn_c = (mn_c < pixel.blue) ? mn_c : pixel.blue;
        if (mx_c == pixel.red)
        begin
            sec_c = SEC_RED;
            n_c   = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
        end
        else if (mx_c == pixel.green)
        begin
            sec_c = SEC_GREEN;
            n_c   = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
        end
        else
        begin
            sec_c = SEC_BLUE;
            n_c   = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
        end
    end

    logic                 v1_reg;
    logic [CH_W-1:0]      mx1_reg, d1_reg;
    logic [1:0]           sec1_reg;
    logic signed [CH_W:0] n1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx1_reg  <= mx_c;
            d1_reg   <= mx_c - mn_c;
            sec1_reg <= sec_c;
            n1_reg   <= n_c;
        end
    end

    // stage 2: hue numerator base*d + 60*n, divider operands
    logic [16:0]        base_d;
    logic signed [18:0] m_s;
    logic [16:0]        m_c;

    always_comb
    begin
        case (sec1_reg)
            SEC_RED:   base_d = 17'(d1_reg) * 17'd360;
            SEC_GREEN: base_d = 17'(d1_reg) * 17'd120;
            SEC_BLUE:  base_d = 17'(d1_reg) * 17'd240;
            default:   base_d = '0;
        endcase
        m_s = $signed({2'b00, base_d}) + n1_reg * 19'sd60;
        m_c = m_s[16:0];
    end

    logic            v2_reg;
    logic [HNW-1:0]  hdvd2_reg;
    logic [DVW-1:0]  hdvs2_reg;
    logic [SNW-1:0]  sdvd2_reg;
    logic [DVW-1:0]  sdvs2_reg;
    logic [CH_W-1:0] mx2_reg;
    logic            ach2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hdvd2_reg <= (HNW'(m_c) << (HUE_FRAC_BITS + 1)) + HNW'(d1_reg);
            hdvs2_reg <= {d1_reg, 1'b0};
            sdvd2_reg <= SNW'(d1_reg) * SNW'(510) + SNW'(mx1_reg);
            sdvs2_reg <= {mx1_reg, 1'b0};
            mx2_reg   <= mx1_reg;
            ach2_reg  <= (d1_reg == '0);
        end
    end

    // dividers
    logic [HQW-1:0] hue_q;
    logic [SQW-1:0] sat_q;

    rhc_divider #(
        .NW(HNW),
        .DW(DVW),
        .QW(HQW)
    ) u_hue_div (
        .clk      (clk),
        .en       (adv),
        .dividend (hdvd2_reg),
        .divisor  (hdvs2_reg),
        .quotient (hue_q)
    );

    rhc_divider #(
        .NW(SNW),
        .DW(DVW),
        .QW(SQW)
    ) u_sat_div (
        .clk      (clk),
        .en       (adv),
        .dividend (sdvd2_reg),
        .divisor  (sdvs2_reg),
        .quotient (sat_q)
    );

    // side band alongside the hue divider
    logic            vd_reg  [HQW];
    logic [CH_W-1:0] mxd_reg [HQW];
    logic            achd_reg[HQW];
    logic [CH_W-1:0] satd_reg[SATPAD];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HQW; i++)
                vd_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vd_reg[0] <= v2_reg;
            for (int i = 1; i < HQW; i++)
                vd_reg[i] <= vd_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mxd_reg[0]  <= mx2_reg;
            achd_reg[0] <= ach2_reg;
            for (int i = 1; i < HQW; i++)
            begin
                mxd_reg[i]  <= mxd_reg[i-1];
                achd_reg[i] <= achd_reg[i-1];
            end
            satd_reg[0] <= sat_q;
            for (int i = 1; i < SATPAD; i++)
                satd_reg[i] <= satd_reg[i-1];
        end
    end

    // output: wrap hue, force hue and saturation of achromatic results to zero
    logic           hsv_valid_reg;
    hsv_t           hsv_reg;
    hsv_t           hsv_next;
    logic [HQW-1:0] hue_wrap;
    logic           ach_last;

    always_comb
    begin
        ach_last = achd_reg[HQW-1];
        hue_wrap = (hue_q >= FULL) ? hue_q - FULL : hue_q;
        hsv_next.hue        = ach_last ? '0 : HUE_W'(hue_wrap);
        hsv_next.saturation = ach_last ? '0 : satd_reg[SATPAD-1];
        hsv_next.brightness = mxd_reg[HQW-1];
        hsv_next.achromatic = ach_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hsv_valid_reg <= 1'b0;
        else if (adv)
            hsv_valid_reg <= vd_reg[HQW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            hsv_reg <= hsv_next;
    end

    assign hsv_valid = hsv_valid_reg;
    assign hsv       = hsv_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

class hsv_scoreboard;

    rhc_pkg::hsv_t hsv_due_q[$];
    int            errors;

    function new();
        errors = 0;
    endfunction

    // Fixed-point RGB to HSV, rounding half up on both divisions
    function rhc_pkg::hsv_t convert_pixel(rhc_pkg::rgb_t p);
        longint        r, g, b, mx, mn, d, base, n, t, hue_l, sat_l, full;
        rhc_pkg::hsv_t h;
        r     = p.red;
        g     = p.green;
        b     = p.blue;
        mx    = (r > g) ? r : g;
        mx    = (mx > b) ? mx : b;
        mn    = (r < g) ? r : g;
        mn    = (mn < b) ? mn : b;
        d     = mx - mn;
        full  = 360 * (64'sd1 << rhc_pkg::HUE_FRAC_BITS_DEF);
        hue_l = 0;
        sat_l = 0;
        if (d != 0)
        begin
            // ties go to red first, then green
            if (mx == r)
            begin
                base = 360;
                n    = g - b;
            end
            else if (mx == g)
            begin
                base = 120;
                n    = b - r;
            end
            else
            begin
                base = 240;
                n    = r - g;
            end
            t     = (base * d + 60 * n) * (64'sd1 << rhc_pkg::HUE_FRAC_BITS_DEF);
            hue_l = (2 * t + d) / (2 * d);
            if (hue_l >= full)
                hue_l = hue_l - full;
        end
        if (mx != 0)
            sat_l = (2 * d * 255 + mx) / (2 * mx);
        h.hue        = hue_l[rhc_pkg::HUE_W-1:0];
        h.saturation = sat_l[rhc_pkg::CH_W-1:0];
        h.brightness = mx[rhc_pkg::CH_W-1:0];
        h.achromatic = (d == 0);
        return h;
    endfunction

    function void note_pixel(rhc_pkg::rgb_t p);
        hsv_due_q.push_back(convert_pixel(p));
    endfunction

    function void check_hsv(rhc_pkg::hsv_t got);
        rhc_pkg::hsv_t exp_h;
        if (hsv_due_q.size() == 0)
        begin
            $error("hsv item with none expected: hue %0d sat %0d val %0d achromatic %0d",
                   got.hue, got.saturation, got.brightness, got.achromatic);
            errors++;
            return;
        end
        exp_h = hsv_due_q.pop_front();
        if (got.hue !== exp_h.hue)
        begin
            $error("hue expected %0d got %0d", exp_h.hue, got.hue);
            errors++;
        end
        if (got.saturation !== exp_h.saturation)
        begin
            $error("saturation expected %0d got %0d", exp_h.saturation, got.saturation);
            errors++;
        end
        if (got.brightness !== exp_h.brightness)
        begin
            $error("brightness expected %0d got %0d", exp_h.brightness, got.brightness);
            errors++;
        end
        if (got.achromatic !== exp_h.achromatic)
        begin
            $error("achromatic expected %0d got %0d", exp_h.achromatic, got.achromatic);
            errors++;
        end
    endfunction

    function int pending();
        return hsv_due_q.size();
    endfunction

endclass

module tb_top;
    import rhc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int SEGMENT_ITEMS = 125;
    localparam int DRAIN_CYCLES  = 3 * (HUE_FRAC_BITS_DEF + 12);

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    rgb_t pixel       = '0;
    logic hsv_valid;
    logic hsv_stall   = 1'b0;
    hsv_t hsv;

    bit src_quiet = 1'b0;
    bit snk_quiet = 1'b0;
    int cycle_count = 0;

    hsv_scoreboard sb = new();

    rgb_to_hsv_converter_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .hsv_valid   (hsv_valid),
        .hsv_stall   (hsv_stall),
        .hsv         (hsv)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
                sb.note_pixel(pixel);
            if (hsv_valid && !hsv_stall)
                sb.check_hsv(hsv);
        end
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic rgb_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        rgb_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        return p;
    endfunction

    // Mix of uniform pixels, ties for the maximum, grays, dim pixels and near-grays
    function automatic rgb_t random_pixel();
        rgb_t        p;
        logic [7:0]  hi, lo;
        p = rgb_t'(24'($urandom));
        case ($urandom_range(0, 9))
            0, 1:
            begin
                hi = 8'($urandom_range(1, 255));
                lo = 8'($urandom_range(0, hi - 1));
                case ($urandom_range(0, 2))
                    0: p = mk_pixel(hi, hi, lo);
                    1: p = mk_pixel(lo, hi, hi);
                    default: p = mk_pixel(hi, lo, hi);
                endcase
            end
            2:
            begin
                hi = 8'($urandom);
                p  = mk_pixel(hi, hi, hi);
            end
            3:
                p = mk_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                             8'($urandom_range(0, 3)));
            4:
            begin
                hi = 8'($urandom_range(2, 255));
                p  = mk_pixel(8'(hi - $urandom_range(0, 2)), 8'(hi - $urandom_range(0, 2)),
                              8'(hi - $urandom_range(0, 2)));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input rgb_t p);
        int gap;
        gap = draw_wait(src_quiet);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do
            @(posedge clk);
        while (pixel_stall);
    endtask

    task automatic drain_results();
        pixel_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Result side: stall for a random stretch, then take one item
    initial
    begin
        int n;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            n = draw_wait(snk_quiet);
            if (n > 0)
            begin
                hsv_stall <= 1'b1;
                repeat (n) @(posedge clk);
                hsv_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!hsv_valid);
        end
    end

    initial
    begin
        rgb_t directed_q[$];
        directed_q = '{
            mk_pixel(8'd0,   8'd0,   8'd0),
            mk_pixel(8'd255, 8'd255, 8'd255),
            mk_pixel(8'd128, 8'd128, 8'd128),
            mk_pixel(8'd1,   8'd1,   8'd1),
            mk_pixel(8'd255, 8'd0,   8'd0),
            mk_pixel(8'd0,   8'd255, 8'd0),
            mk_pixel(8'd0,   8'd0,   8'd255),
            mk_pixel(8'd255, 8'd255, 8'd0),
            mk_pixel(8'd0,   8'd255, 8'd255),
            mk_pixel(8'd255, 8'd0,   8'd255),
            mk_pixel(8'd255, 8'd0,   8'd1),
            mk_pixel(8'd255, 8'd1,   8'd0),
            mk_pixel(8'd1,   8'd0,   8'd0),
            mk_pixel(8'd0,   8'd1,   8'd0),
            mk_pixel(8'd0,   8'd0,   8'd1),
            mk_pixel(8'd1,   8'd0,   8'd1),
            mk_pixel(8'd255, 8'd254, 8'd254),
            mk_pixel(8'd255, 8'd128, 8'd0),
            mk_pixel(8'd200, 8'd100, 8'd50),
            mk_pixel(8'd10,  8'd20,  8'd30),
            mk_pixel(8'd2,   8'd1,   8'd0),
            mk_pixel(8'd3,   8'd2,   8'd3),
            mk_pixel(8'd127, 8'd128, 8'd254)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin
                foreach (directed_q[i])
                    send_pixel(directed_q[i]);

                // hold off until the pipeline is empty, then restart from idle
                drain_results();

                for (int i = 0; i < RANDOM_ITEMS; i++)
                begin
                    if (i % SEGMENT_ITEMS == 0)
                    begin
                        case ((i / SEGMENT_ITEMS) % 4)
                            0: begin src_quiet = 1'b0; snk_quiet = 1'b0; end
                            1: begin src_quiet = 1'b1; snk_quiet = 1'b1; end
                            2: begin src_quiet = 1'b1; snk_quiet = 1'b0; end
                            default: begin src_quiet = 1'b0; snk_quiet = 1'b1; end
                        endcase
                    end
                    send_pixel(random_pixel());
                end

                drain_results();
                repeat (DRAIN_CYCLES) @(posedge clk);

                if (sb.errors == 0 && sb.pending() == 0)
                    $display("status: pass");
                else
                    $display("status: fail");
                $finish;
            end
            begin
                while (cycle_count < CYCLE_LIMIT)
                    @(posedge clk);
                $error("timeout after %0d cycles, %0d items outstanding",
                       cycle_count, sb.pending());
                $display("status: fail");
                $finish;
            end
        join_any
    end

endmodule
